### rtl/core/rlfd_pkg.sv
// Package for the radio link frame decoder: byte and command codes, frame lengths,
// result kinds, status flag positions and the packed result item layout.
// Has no dependencies of its own.
package rlfd_pkg;

   localparam int STORE_DEPTH = 13;
   localparam int CNT_W       = 4;
   localparam int RSP_DATA_W  = 208;

   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_HB  = "S";

   localparam logic [7:0] CMD_ACTIVE      = "U";
   localparam logic [7:0] CMD_STANDBY     = "R";
   localparam logic [7:0] CMD_AUDIO       = "A";
   localparam logic [7:0] CMD_SWAP        = "C";
   localparam logic [7:0] CMD_DUAL_ON     = "O";
   localparam logic [7:0] CMD_DUAL_OFF    = "o";
   localparam logic [7:0] CMD_SPACING_833 = "8";
   localparam logic [7:0] CMD_SPACING_25K = "6";
   localparam logic [7:0] CMD_BAT_LOW     = "B";
   localparam logic [7:0] CMD_BAT_OK      = "D";
   localparam logic [7:0] CMD_RX_OFF      = "V";
   localparam logic [7:0] CMD_TX_ON       = "K";
   localparam logic [7:0] CMD_RXTX_OFF    = "Y";
   localparam logic [7:0] CMD_RX_ACT      = "M";
   localparam logic [7:0] CMD_RX_SBY      = "m";

   localparam logic [CNT_W-1:0] LEN_UNKNOWN = 4'd0;
   localparam logic [CNT_W-1:0] LEN_SINGLE  = 4'd1;
   localparam logic [CNT_W-1:0] LEN_SHORT   = 4'd2;
   localparam logic [CNT_W-1:0] LEN_AUDIO   = 4'd6;
   localparam logic [CNT_W-1:0] LEN_FREQ    = 4'd13;

   localparam logic [17:0] KHZ_PER_MHZ  = 18'd1000;
   localparam logic [17:0] KHZ_PER_CHAN = 18'd5;

   localparam logic [4:0] KIND_HB       = 5'd0;
   localparam logic [4:0] KIND_ACK      = 5'd1;
   localparam logic [4:0] KIND_NAK      = 5'd2;
   localparam logic [4:0] KIND_ACTIVE   = 5'd3;
   localparam logic [4:0] KIND_STANDBY  = 5'd4;
   localparam logic [4:0] KIND_AUDIO    = 5'd5;
   localparam logic [4:0] KIND_SWAP     = 5'd6;
   localparam logic [4:0] KIND_DUAL_ON  = 5'd7;
   localparam logic [4:0] KIND_DUAL_OFF = 5'd8;
   localparam logic [4:0] KIND_833      = 5'd9;
   localparam logic [4:0] KIND_25K      = 5'd10;
   localparam logic [4:0] KIND_BAT_LOW  = 5'd11;
   localparam logic [4:0] KIND_BAT_OK   = 5'd12;
   localparam logic [4:0] KIND_RX_OFF   = 5'd13;
   localparam logic [4:0] KIND_TX_ON    = 5'd14;
   localparam logic [4:0] KIND_RXTX_OFF = 5'd15;
   localparam logic [4:0] KIND_RX_ACT   = 5'd16;
   localparam logic [4:0] KIND_RX_SBY   = 5'd17;
   localparam logic [4:0] KIND_INFO     = 5'd18;
   localparam logic [4:0] KIND_UNKNOWN  = 5'd19;
   localparam logic [4:0] KIND_JUNK     = 5'd20;

   localparam int FLAG_ACT_VALID  = 0;
   localparam int FLAG_SBY_VALID  = 1;
   localparam int FLAG_AUD_VALID  = 2;
   localparam int FLAG_DUAL_VALID = 3;
   localparam int FLAG_DUAL       = 4;
   localparam int FLAG_833        = 5;
   localparam int FLAG_LOW_BAT    = 6;
   localparam int FLAG_TX         = 7;
   localparam int FLAG_RX_ACT     = 8;
   localparam int FLAG_RX_SBY     = 9;

   typedef struct packed {
      logic [6:0]  pad;
      logic [9:0]  status_flags;
      logic [7:0]  vox_level;
      logic [7:0]  squelch_level;
      logic [7:0]  volume_level;
      logic [63:0] standby_label;
      logic [63:0] active_label;
      logic [17:0] standby_freq_khz;
      logic [17:0] active_freq_khz;
      logic        first_detection;
      logic        send_heartbeat_reply;
      logic        checksum_failed;
   } rsp_data_type;

   // Commands that only carry information and change no state.
   function automatic logic is_info_cmd(input logic [7:0] cmd);
      logic hit;
      case (cmd)
         "1", "2", "3", "4", "J", "L", "E", "H",
         "e", "F", "a", "b", "c", "d", "f", "g", "h": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

### rtl/core/radio_link_frame_decoder_unit.sv
// Top level of the radio link frame decoder: frames received bytes and decodes them.
// Depends on rlfd_pkg for codes, lengths and the result item layout.
//
// The req_ channel carries one received byte per item. The rsp_ channel carries one
// item for every completed frame (heartbeat, ACK, NAK, STX or junk frame) and nothing for
// bytes in the middle of a frame. Each rsp_ item holds the frame kind in rsp_tuser
// and the checksum, heartbeat and detection flags together with the full radio state
// after the frame in rsp_tdata.
// A byte is registered on acceptance and decoded from the input register; a frame's item
// is registered in the result register as its last byte is decoded. One byte is taken
// every cycle while the result register is empty or being drained; the single decode
// stage sets that figure. When the receiver stalls, the held item blocks the decode stage
// and the input register, and req_tready drops once both are full.
// Reset clears the frame position, the expected length, the detection flag, the
// frequencies, names, audio levels and status flags. The frame byte store is not
// cleared; only bytes written in the current frame are ever read.
module radio_link_frame_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // rx_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // checksum_failed, send_heartbeat_reply, first_detection, active_freq_khz,
   // standby_freq_khz, active_label, standby_label, volume_level, squelch_level,
   // vox_level, status_flags, zero fill
   output logic [rlfd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [4:0]                         rsp_tuser    // frame_kind
);
   import rlfd_pkg::*;

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic [7:0]             store_ff [STORE_DEPTH];
   logic [CNT_W-1:0]       byte_count_ff, byte_count_in;
   logic [CNT_W-1:0]       exp_len_ff, exp_len_in;
   logic                   radio_found_ff, radio_found_in;
   logic [17:0]            active_khz_ff, active_khz_in;
   logic [17:0]            standby_khz_ff, standby_khz_in;
   logic [63:0]            active_text_ff, active_text_in;
   logic [63:0]            standby_text_ff, standby_text_in;
   logic [23:0]            audio_ff, audio_in;
   logic [9:0]             flags_ff, flags_in;
   logic                   rsp_valid_ff;
   rsp_data_type           rsp_data_ff, rsp_data_in;
   logic [4:0]             rsp_kind_ff, rsp_kind_in;

   logic                   out_free;
   logic                   fire;
   logic                   done;
   logic [CNT_W-1:0]       wr_idx;
   logic [CNT_W-1:0]       new_count;
   logic [7:0]             frame_view [STORE_DEPTH];
   logic                   freq_ok;
   logic                   audio_ok;
   logic [17:0]            freq_khz;
   logic [63:0]            name_raw;
   logic                   chk_fail;
   logic                   hb_reply;
   logic                   first_det;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_comb begin
      logic [CNT_W-1:0] base;
      base = byte_count_ff;
      if (exp_len_ff == LEN_UNKNOWN && in_byte_ff == BYTE_STX) begin
         base = '0;
      end
      if (base >= CNT_W'(STORE_DEPTH)) begin
         base = '0;
      end
      wr_idx    = base;
      new_count = base + CNT_W'(1);
   end

   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         frame_view[i] = (wr_idx == CNT_W'(i)) ? in_byte_ff : store_ff[i];
      end
   end

   always_comb begin
      exp_len_in = exp_len_ff;
      if (new_count == LEN_SINGLE &&
          (in_byte_ff == BYTE_HB || in_byte_ff == BYTE_ACK || in_byte_ff == BYTE_NAK)) begin
         exp_len_in = LEN_SINGLE;
      end
      if (new_count == LEN_SHORT) begin
         if (in_byte_ff == CMD_ACTIVE || in_byte_ff == CMD_STANDBY) begin
            exp_len_in = LEN_FREQ;
         end else if (in_byte_ff == CMD_AUDIO) begin
            exp_len_in = LEN_AUDIO;
         end else begin
            exp_len_in = LEN_SHORT;
         end
      end
      done = (new_count == exp_len_in);
      if (done) begin
         exp_len_in = LEN_UNKNOWN;
      end
      byte_count_in = done ? '0 : new_count;
   end

   assign freq_ok  = (frame_view[12] == (frame_view[2] ^ frame_view[3]));
   assign audio_ok = ({1'b0, frame_view[5]} == ({1'b0, frame_view[3]} + {1'b0, frame_view[4]}));
   assign freq_khz = 18'(frame_view[2]) * KHZ_PER_MHZ + 18'(frame_view[3]) * KHZ_PER_CHAN;
   assign name_raw = {frame_view[11], frame_view[10], frame_view[9], frame_view[8],
                      frame_view[7], frame_view[6], frame_view[5], frame_view[4]};

   always_comb begin
      radio_found_in  = radio_found_ff;
      active_khz_in   = active_khz_ff;
      standby_khz_in  = standby_khz_ff;
      active_text_in  = active_text_ff;
      standby_text_in = standby_text_ff;
      audio_in        = audio_ff;
      flags_in        = flags_ff;
      chk_fail        = 1'b0;
      hb_reply        = 1'b0;
      first_det       = 1'b0;
      rsp_kind_in     = KIND_JUNK;
      if (frame_view[0] == BYTE_HB) begin
         hb_reply       = 1'b1;
         first_det      = !radio_found_ff;
         radio_found_in = 1'b1;
         rsp_kind_in    = KIND_HB;
      end else if (frame_view[0] == BYTE_ACK) begin
         rsp_kind_in = KIND_ACK;
      end else if (frame_view[0] == BYTE_NAK) begin
         rsp_kind_in = KIND_NAK;
      end else if (frame_view[0] == BYTE_STX) begin
         rsp_kind_in = KIND_UNKNOWN;
         if (is_info_cmd(frame_view[1])) begin
            rsp_kind_in = KIND_INFO;
         end
         case (frame_view[1])
            CMD_ACTIVE: begin
               rsp_kind_in              = KIND_ACTIVE;
               flags_in[FLAG_ACT_VALID] = freq_ok;
               chk_fail                 = !freq_ok;
               if (freq_ok) begin
                  active_khz_in  = freq_khz;
                  active_text_in = name_raw;
               end
            end
            CMD_STANDBY: begin
               rsp_kind_in              = KIND_STANDBY;
               flags_in[FLAG_SBY_VALID] = freq_ok;
               chk_fail                 = !freq_ok;
               if (freq_ok) begin
                  standby_khz_in  = freq_khz;
                  standby_text_in = name_raw;
               end
            end
            CMD_AUDIO: begin
               rsp_kind_in              = KIND_AUDIO;
               flags_in[FLAG_AUD_VALID] = audio_ok;
               chk_fail                 = !audio_ok;
               if (audio_ok) begin
                  audio_in = {frame_view[4], frame_view[3], frame_view[2]};
               end
            end
            CMD_SWAP: begin
               rsp_kind_in              = KIND_SWAP;
               flags_in[FLAG_ACT_VALID] = 1'b0;
               flags_in[FLAG_SBY_VALID] = 1'b0;
               active_khz_in            = standby_khz_ff;
               standby_khz_in           = active_khz_ff;
               active_text_in           = standby_text_ff;
               standby_text_in          = active_text_ff;
            end
            CMD_DUAL_ON: begin
               rsp_kind_in               = KIND_DUAL_ON;
               flags_in[FLAG_DUAL_VALID] = 1'b1;
               flags_in[FLAG_DUAL]       = 1'b1;
            end
            CMD_DUAL_OFF: begin
               rsp_kind_in               = KIND_DUAL_OFF;
               flags_in[FLAG_DUAL_VALID] = 1'b1;
               flags_in[FLAG_DUAL]       = 1'b0;
            end
            CMD_SPACING_833: begin
               rsp_kind_in        = KIND_833;
               flags_in[FLAG_833] = 1'b1;
            end
            CMD_SPACING_25K: begin
               rsp_kind_in        = KIND_25K;
               flags_in[FLAG_833] = 1'b0;
            end
            CMD_BAT_LOW: begin
               rsp_kind_in            = KIND_BAT_LOW;
               flags_in[FLAG_LOW_BAT] = 1'b1;
            end
            CMD_BAT_OK: begin
               rsp_kind_in            = KIND_BAT_OK;
               flags_in[FLAG_LOW_BAT] = 1'b0;
            end
            CMD_RX_OFF: begin
               rsp_kind_in           = KIND_RX_OFF;
               flags_in[FLAG_RX_ACT] = 1'b0;
               flags_in[FLAG_RX_SBY] = 1'b0;
            end
            CMD_TX_ON: begin
               rsp_kind_in       = KIND_TX_ON;
               flags_in[FLAG_TX] = 1'b1;
            end
            CMD_RXTX_OFF: begin
               rsp_kind_in       = KIND_RXTX_OFF;
               flags_in[FLAG_TX] = 1'b0;
            end
            CMD_RX_ACT: begin
               rsp_kind_in           = KIND_RX_ACT;
               flags_in[FLAG_RX_ACT] = 1'b1;
            end
            CMD_RX_SBY: begin
               rsp_kind_in           = KIND_RX_SBY;
               flags_in[FLAG_RX_SBY] = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in                      = '0;
      rsp_data_in.checksum_failed      = chk_fail;
      rsp_data_in.send_heartbeat_reply = hb_reply;
      rsp_data_in.first_detection      = first_det;
      rsp_data_in.active_freq_khz      = active_khz_in;
      rsp_data_in.standby_freq_khz     = standby_khz_in;
      rsp_data_in.active_label         = active_text_in;
      rsp_data_in.standby_label        = standby_text_in;
      rsp_data_in.volume_level         = audio_in[7:0];
      rsp_data_in.squelch_level        = audio_in[15:8];
      rsp_data_in.vox_level            = audio_in[23:16];
      rsp_data_in.status_flags         = flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         byte_count_ff   <= '0;
         exp_len_ff      <= LEN_UNKNOWN;
         radio_found_ff  <= 1'b0;
         active_khz_ff   <= '0;
         standby_khz_ff  <= '0;
         active_text_ff  <= '0;
         standby_text_ff <= '0;
         audio_ff        <= '0;
         flags_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= fire && done;
         end
         if (fire) begin
            byte_count_ff <= byte_count_in;
            exp_len_ff    <= exp_len_in;
            if (done) begin
               radio_found_ff  <= radio_found_in;
               active_khz_ff   <= active_khz_in;
               standby_khz_ff  <= standby_khz_in;
               active_text_ff  <= active_text_in;
               standby_text_ff <= standby_text_in;
               audio_ff        <= audio_in;
               flags_ff        <= flags_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (fire) begin
         store_ff[wr_idx] <= in_byte_ff;
      end
      if (fire && done) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // The frame position never reaches a known length without the frame completing.
   a_count_below_length: assert property (@(posedge clock) disable iff (reset)
      (exp_len_ff != LEN_UNKNOWN) |-> (byte_count_ff < exp_len_ff))
      else $error("byte count reached the expected frame length");

   a_length_legal: assert property (@(posedge clock) disable iff (reset)
      exp_len_ff == LEN_UNKNOWN || exp_len_ff == LEN_SINGLE || exp_len_ff == LEN_SHORT ||
      exp_len_ff == LEN_AUDIO || exp_len_ff == LEN_FREQ)
      else $error("expected frame length holds an impossible value");

   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      radio_found_ff |=> radio_found_ff)
      else $error("radio detection flag cleared without reset");

   a_first_is_heartbeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.first_detection) |->
      (rsp_data_ff.send_heartbeat_reply && rsp_kind_ff == KIND_HB))
      else $error("first detection reported on a frame that is not a heartbeat");

   a_stall_blocks_decode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(byte_count_ff) && $stable(flags_ff))
      else $error("decode state advanced while the result item was stalled");

endmodule

### tb/sv/radio_link_frame_decoder_unit_test.sv
// Self-checking testbench for radio_link_frame_decoder_unit: streams received bytes,
// predicts every decoded frame item and compares it field by field at the rsp_ side.
// Depends on rlfd_pkg and the decoder RTL only.
module radio_link_frame_decoder_unit_test;
   import rlfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS  = 400;
   localparam int HOLD_CYCLES  = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PRINT_CAP    = 30;

   localparam logic [7:0] STATE_CMDS [13] = '{
      CMD_SWAP, CMD_DUAL_ON, CMD_DUAL_OFF, CMD_SPACING_833, CMD_SPACING_25K,
      CMD_BAT_LOW, CMD_BAT_OK, CMD_RX_OFF, CMD_TX_ON, CMD_RXTX_OFF,
      CMD_RX_ACT, CMD_RX_SBY, CMD_SWAP
   };
   localparam logic [7:0] INFO_CMDS [17] = '{
      "1", "2", "3", "4", "J", "L", "E", "H", "e", "F", "a", "b", "c", "d", "f", "g", "h"
   };

   typedef struct packed {
      logic [4:0]   kind;
      rsp_data_type data;
   } frame_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [4:0]            rsp_tuser;

   logic [7:0]       rx_bytes_q[$];
   frame_result_type frame_results_q[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int phase_idx = -1;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int mismatches = 0;
   int bytes_accepted = 0;
   int frames_checked = 0;
   int stall_cycles = 0;

   // Predictor state, starting from the reset values.
   logic [7:0]  frame_buf [0:STORE_DEPTH-1];
   int          frame_pos = 0;
   logic [3:0]  frame_len = LEN_UNKNOWN;
   logic        radio_seen = 1'b0;
   logic [17:0] act_khz = '0;
   logic [17:0] sby_khz = '0;
   logic [63:0] act_name = '0;
   logic [63:0] sby_name = '0;
   logic [7:0]  vol_lvl = '0;
   logic [7:0]  sql_lvl = '0;
   logic [7:0]  vox_lvl = '0;
   logic [9:0]  flags = '0;

   radio_link_frame_decoder_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [17:0] frame_freq_khz();
      return 18'(frame_buf[2]) * KHZ_PER_MHZ + 18'(frame_buf[3]) * KHZ_PER_CHAN;
   endfunction

   function automatic logic [63:0] frame_name();
      return {frame_buf[11], frame_buf[10], frame_buf[9], frame_buf[8],
              frame_buf[7], frame_buf[6], frame_buf[5], frame_buf[4]};
   endfunction

   function automatic logic freq_sum_ok();
      return frame_buf[12] == (frame_buf[2] ^ frame_buf[3]);
   endfunction

   task automatic decode_rx_byte(input logic [7:0] b);
      frame_result_type r;
      logic [17:0]      tmp_khz;
      logic [63:0]      tmp_name;
      logic             is_info;
      if (frame_len == LEN_UNKNOWN && b == BYTE_STX) frame_pos = 0;
      if (frame_pos >= STORE_DEPTH) frame_pos = 0;
      frame_buf[frame_pos] = b;
      frame_pos++;
      if (frame_pos == 1 && (b == BYTE_HB || b == BYTE_ACK || b == BYTE_NAK))
         frame_len = LEN_SINGLE;
      if (frame_pos == 2) begin
         if (b == CMD_ACTIVE || b == CMD_STANDBY) frame_len = LEN_FREQ;
         else if (b == CMD_AUDIO) frame_len = LEN_AUDIO;
         else frame_len = LEN_SHORT;
      end
      if (frame_pos != int'(frame_len)) return;

      r = '0;
      case (frame_buf[0])
         BYTE_HB: begin
            r.kind = KIND_HB;
            r.data.send_heartbeat_reply = 1'b1;
            r.data.first_detection = !radio_seen;
            radio_seen = 1'b1;
         end
         BYTE_ACK: r.kind = KIND_ACK;
         BYTE_NAK: r.kind = KIND_NAK;
         BYTE_STX: begin
            case (frame_buf[1])
               CMD_ACTIVE: begin
                  r.kind = KIND_ACTIVE;
                  flags[FLAG_ACT_VALID] = 1'b0;
                  if (!freq_sum_ok()) begin
                     r.data.checksum_failed = 1'b1;
                  end else begin
                     flags[FLAG_ACT_VALID] = 1'b1;
                     act_khz = frame_freq_khz();
                     act_name = frame_name();
                  end
               end
               CMD_STANDBY: begin
                  r.kind = KIND_STANDBY;
                  flags[FLAG_SBY_VALID] = 1'b0;
                  if (!freq_sum_ok()) begin
                     r.data.checksum_failed = 1'b1;
                  end else begin
                     flags[FLAG_SBY_VALID] = 1'b1;
                     sby_khz = frame_freq_khz();
                     sby_name = frame_name();
                  end
               end
               CMD_AUDIO: begin
                  r.kind = KIND_AUDIO;
                  flags[FLAG_AUD_VALID] = 1'b0;
                  if ({1'b0, frame_buf[5]} != {1'b0, frame_buf[3]} + {1'b0, frame_buf[4]}) begin
                     r.data.checksum_failed = 1'b1;
                  end else begin
                     flags[FLAG_AUD_VALID] = 1'b1;
                     vol_lvl = frame_buf[2];
                     sql_lvl = frame_buf[3];
                     vox_lvl = frame_buf[4];
                  end
               end
               CMD_SWAP: begin
                  r.kind = KIND_SWAP;
                  flags[FLAG_ACT_VALID] = 1'b0;
                  flags[FLAG_SBY_VALID] = 1'b0;
                  tmp_khz = act_khz;
                  tmp_name = act_name;
                  act_khz = sby_khz;
                  act_name = sby_name;
                  sby_khz = tmp_khz;
                  sby_name = tmp_name;
               end
               CMD_DUAL_ON: begin
                  r.kind = KIND_DUAL_ON;
                  flags[FLAG_DUAL_VALID] = 1'b1;
                  flags[FLAG_DUAL] = 1'b1;
               end
               CMD_DUAL_OFF: begin
                  r.kind = KIND_DUAL_OFF;
                  flags[FLAG_DUAL_VALID] = 1'b1;
                  flags[FLAG_DUAL] = 1'b0;
               end
               CMD_SPACING_833: begin
                  r.kind = KIND_833;
                  flags[FLAG_833] = 1'b1;
               end
               CMD_SPACING_25K: begin
                  r.kind = KIND_25K;
                  flags[FLAG_833] = 1'b0;
               end
               CMD_BAT_LOW: begin
                  r.kind = KIND_BAT_LOW;
                  flags[FLAG_LOW_BAT] = 1'b1;
               end
               CMD_BAT_OK: begin
                  r.kind = KIND_BAT_OK;
                  flags[FLAG_LOW_BAT] = 1'b0;
               end
               CMD_RX_OFF: begin
                  r.kind = KIND_RX_OFF;
                  flags[FLAG_RX_ACT] = 1'b0;
                  flags[FLAG_RX_SBY] = 1'b0;
               end
               CMD_TX_ON: begin
                  r.kind = KIND_TX_ON;
                  flags[FLAG_TX] = 1'b1;
               end
               CMD_RXTX_OFF: begin
                  r.kind = KIND_RXTX_OFF;
                  flags[FLAG_TX] = 1'b0;
               end
               CMD_RX_ACT: begin
                  r.kind = KIND_RX_ACT;
                  flags[FLAG_RX_ACT] = 1'b1;
               end
               CMD_RX_SBY: begin
                  r.kind = KIND_RX_SBY;
                  flags[FLAG_RX_SBY] = 1'b1;
               end
               default: begin
                  is_info = 1'b0;
                  foreach (INFO_CMDS[i]) if (INFO_CMDS[i] == frame_buf[1]) is_info = 1'b1;
                  r.kind = is_info ? KIND_INFO : KIND_UNKNOWN;
               end
            endcase
         end
         default: r.kind = KIND_JUNK;
      endcase
      frame_pos = 0;
      frame_len = LEN_UNKNOWN;

      r.data.active_freq_khz = act_khz;
      r.data.standby_freq_khz = sby_khz;
      r.data.active_label = act_name;
      r.data.standby_label = sby_name;
      r.data.volume_level = vol_lvl;
      r.data.squelch_level = sql_lvl;
      r.data.vox_level = vox_lvl;
      r.data.status_flags = flags;
      frame_results_q.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < PRINT_CAP)
         $display("%0t mismatch in frame %0d, %s: got %0h, expected %0h",
                  $realtime, frames_checked, what, got, want);
      mismatches++;
   endtask

   task automatic check_frame_item(input logic [4:0] kind, input rsp_data_type d);
      frame_result_type w;
      if (frame_results_q.size() == 0) begin
         report_mismatch("item with none expected, kind", 64'(kind), '0);
         return;
      end
      w = frame_results_q.pop_front();
      if (kind != w.kind) report_mismatch("frame_kind", 64'(kind), 64'(w.kind));
      if (d.checksum_failed != w.data.checksum_failed)
         report_mismatch("checksum_failed", 64'(d.checksum_failed),
                         64'(w.data.checksum_failed));
      if (d.send_heartbeat_reply != w.data.send_heartbeat_reply)
         report_mismatch("send_heartbeat_reply", 64'(d.send_heartbeat_reply),
                         64'(w.data.send_heartbeat_reply));
      if (d.first_detection != w.data.first_detection)
         report_mismatch("first_detection", 64'(d.first_detection),
                         64'(w.data.first_detection));
      if (d.active_freq_khz != w.data.active_freq_khz)
         report_mismatch("active_freq_khz", 64'(d.active_freq_khz),
                         64'(w.data.active_freq_khz));
      if (d.standby_freq_khz != w.data.standby_freq_khz)
         report_mismatch("standby_freq_khz", 64'(d.standby_freq_khz),
                         64'(w.data.standby_freq_khz));
      if (d.active_label != w.data.active_label)
         report_mismatch("active_label", d.active_label, w.data.active_label);
      if (d.standby_label != w.data.standby_label)
         report_mismatch("standby_label", d.standby_label, w.data.standby_label);
      if (d.volume_level != w.data.volume_level)
         report_mismatch("volume_level", 64'(d.volume_level), 64'(w.data.volume_level));
      if (d.squelch_level != w.data.squelch_level)
         report_mismatch("squelch_level", 64'(d.squelch_level), 64'(w.data.squelch_level));
      if (d.vox_level != w.data.vox_level)
         report_mismatch("vox_level", 64'(d.vox_level), 64'(w.data.vox_level));
      if (d.status_flags != w.data.status_flags)
         report_mismatch("status_flags", 64'(d.status_flags), 64'(w.data.status_flags));
   endtask

   task automatic queue_freq_frame(input logic [7:0] cmd, input logic [7:0] mhz,
                                   input logic [7:0] chan, input logic [63:0] name,
                                   input logic [7:0] chk);
      rx_bytes_q.push_back(BYTE_STX);
      rx_bytes_q.push_back(cmd);
      rx_bytes_q.push_back(mhz);
      rx_bytes_q.push_back(chan);
      for (int i = 0; i < 8; i++) rx_bytes_q.push_back(name[8*i +: 8]);
      rx_bytes_q.push_back(chk);
   endtask

   task automatic queue_audio_frame(input logic [7:0] vol, input logic [7:0] sql,
                                    input logic [7:0] vox, input logic [7:0] chk);
      rx_bytes_q.push_back(BYTE_STX);
      rx_bytes_q.push_back(CMD_AUDIO);
      rx_bytes_q.push_back(vol);
      rx_bytes_q.push_back(sql);
      rx_bytes_q.push_back(vox);
      rx_bytes_q.push_back(chk);
   endtask

   task automatic queue_short_frame(input logic [7:0] cmd);
      rx_bytes_q.push_back(BYTE_STX);
      rx_bytes_q.push_back(cmd);
   endtask

   task automatic queue_random_frame();
      int          pick;
      logic [7:0]  mhz;
      logic [7:0]  chan;
      logic [7:0]  sql;
      logic [7:0]  vox;
      logic [7:0]  chk;
      logic [7:0]  lead;
      logic [63:0] name;
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
         rx_bytes_q.push_back(BYTE_HB);
      end else if (pick < 14) begin
         rx_bytes_q.push_back(BYTE_ACK);
      end else if (pick < 18) begin
         rx_bytes_q.push_back(BYTE_NAK);
      end else if (pick < 34) begin
         mhz = 8'($urandom);
         chan = 8'($urandom);
         name = {$urandom, $urandom};
         chk = mhz ^ chan;
         if ($urandom_range(4, 0) == 0) chk = chk ^ 8'($urandom_range(255, 1));
         queue_freq_frame($urandom_range(1, 0) ? CMD_ACTIVE : CMD_STANDBY,
                          mhz, chan, name, chk);
      end else if (pick < 46) begin
         sql = 8'($urandom);
         if ($urandom_range(9, 0) < 7) begin
            vox = 8'($urandom_range(255 - sql, 0));
            chk = sql + vox;
         end else begin
            vox = 8'($urandom);
            do chk = 8'($urandom); while ({1'b0, chk} == {1'b0, sql} + {1'b0, vox});
         end
         queue_audio_frame(8'($urandom), sql, vox, chk);
      end else if (pick < 70) begin
         queue_short_frame(STATE_CMDS[$urandom_range(12, 0)]);
      end else if (pick < 78) begin
         queue_short_frame(INFO_CMDS[$urandom_range(16, 0)]);
      end else if (pick < 82) begin
         queue_short_frame(8'($urandom));
      end else if (pick < 87) begin
         do lead = 8'($urandom);
         while (lead == BYTE_STX || lead == BYTE_HB || lead == BYTE_ACK || lead == BYTE_NAK);
         rx_bytes_q.push_back(lead);
         rx_bytes_q.push_back(8'($urandom));
      end else if (pick < 92) begin
         // A frame cut short after its start byte; the next start byte restarts it.
         rx_bytes_q.push_back(BYTE_STX);
      end else begin
         repeat ($urandom_range(3, 1)) rx_bytes_q.push_back(8'($urandom));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_rx_byte(req_tdata);
            bytes_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= rx_bytes_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_frame_item(rsp_tuser, rsp_data_type'(rsp_tdata));
            frames_checked++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (phase_idx == 2 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(99, 0) >= recv_idle_pct;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
         $display("[radio_link_frame_decoder_unit] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 3; p++) begin
         @(negedge clock);
         case (p)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (p == 0) begin
            // Two heartbeats so that detection is flagged only once, then ACK and NAK.
            rx_bytes_q.push_back(BYTE_HB);
            rx_bytes_q.push_back(BYTE_HB);
            rx_bytes_q.push_back(BYTE_ACK);
            rx_bytes_q.push_back(BYTE_NAK);
            // Highest frequency, with start and heartbeat bytes inside the name.
            queue_freq_frame(CMD_ACTIVE, 8'hFF, 8'hFF,
                             {8'hFF, 8'h00, BYTE_HB, BYTE_STX, 8'h41, 8'h80, BYTE_STX, 8'h7F},
                             8'h00);
            // The audio sum overflows; its low byte matches but the check still fails.
            queue_audio_frame(8'hFF, 8'hFF, 8'h01, 8'h00);
            queue_short_frame(CMD_SWAP);
            // A junk lead byte followed by a start byte restarts the frame.
            rx_bytes_q.push_back("z");
            queue_short_frame(CMD_TX_ON);
            rx_bytes_q.push_back("q");
            rx_bytes_q.push_back("Q");
         end
         while (rx_bytes_q.size() < PHASE_ITEMS) queue_random_frame();
         phase_idx = p;
         wait (rx_bytes_q.size() == 0 && !req_tvalid && frame_results_q.size() == 0);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_results_q.size() != 0)
         report_mismatch("items never delivered", 64'(frame_results_q.size()), '0);
      $display("Sent %0d received bytes and checked %0d frame items over three pacing phases,",
               bytes_accepted, frames_checked);
      $display("including a long output stall with the input held full.");
      if (mismatches == 0) begin
         $display("[radio_link_frame_decoder_unit] OK");
      end else begin
         $display("[radio_link_frame_decoder_unit] ERROR");
      end
      $finish;
   end

endmodule
